[hdl/bsrr_pkg.sv]
// shared types and constants of the byte shift register random range block
`timescale 1ns / 1ps
`default_nettype none
package bsrr_pkg;

   localparam int NUM_BYTES = 16;
   localparam int IDX_BITS  = 4;
   localparam int WORD_BITS = 32;
   localparam int WORDS     = NUM_BYTES / 4;
   localparam int WORD_SEL_BITS = 2;

   // request kinds
   localparam logic REQ_SEED = 1'b0;
   localparam logic REQ_DRAW = 1'b1;

   // register indexes
   localparam logic CSR_BOUND_A = 1'b0;
   localparam logic CSR_BOUND_B = 1'b1;

   typedef logic [7:0]                  sbyte_type;
   typedef logic [NUM_BYTES-1:0][7:0]   bytes_type;

   // control from the sequencer to the byte register
   typedef struct packed {
      logic                seed_we;
      logic [IDX_BITS-1:0] seed_idx;
      sbyte_type           seed_byte;
      logic                adv;
   } shreg_ctl_type;

endpackage
`default_nettype wire

[hdl/byte_shift_register_random_range_top.sv]
// top level of the byte shift register random range block
`timescale 1ns / 1ps
`default_nettype none
// A seed item stores one byte into the 16-byte register. A draw item
// advances the register once per cycle, req_steps times, and then sees the
// count run out. It then folds the bytes into a 32-bit sum one word per
// cycle. Next it halves the sum, orders the bounds and forms the span, and
// then checks for a full range and starts the remainder unit. The
// bit-serial remainder unit reduces modulo the span at one bit per cycle
// and raises its done flag, and the lower bound is added. The item is then
// placed in the output register once it is free, and the next item is taken
// no sooner. A full 32-bit range skips the remainder unit. One item is worked
// on at a time. req_stall is high while a draw is in progress or its result
// cannot yet be placed in the output register. Bounds are to be written by
// the user through the csr port only while the block is idle; the block
// itself does not enforce this. They are ordered internally.
module byte_shift_register_random_range_top #(
   parameter int STEP_BITS = 16
) (
   input  wire                  clock,
   input  wire                  reset,
   // request channel
   input  wire                  req_valid,
   output logic                 req_stall,
   input  wire                  req_type,
   input  wire  [3:0]           req_seed_index,
   input  wire  [7:0]           req_seed_byte,
   input  wire  [STEP_BITS-1:0] req_steps,
   // result channel
   output logic                 rsp_valid,
   input  wire                  rsp_stall,
   output logic signed [31:0]   rsp_value,
   // register writes
   input  wire                  csr_we,
   input  wire                  csr_index,
   input  wire  [31:0]          csr_wdata
);
   import bsrr_pkg::*;

   // one-hot sequencer states
   typedef enum logic [6:0] {
      S_IDLE  = 7'b0000001,
      S_ADV   = 7'b0000010,
      S_SUM   = 7'b0000100,
      S_PREP  = 7'b0001000,
      S_START = 7'b0010000,
      S_DIV   = 7'b0100000,
      S_OUT   = 7'b1000000
   } state_type;

   state_type                 state_ff, state_in;
   logic [STEP_BITS-1:0]      steps_ff, steps_in;
   logic [WORD_SEL_BITS-1:0]  wsel_ff,  wsel_in;
   logic [WORD_BITS-1:0]      acc_ff,   acc_in;
   logic [WORD_BITS-1:0]      lo_ff,    lo_in;
   logic [WORD_BITS-1:0]      span_ff,  span_in;
   logic [WORD_BITS-1:0]      res_ff,   res_in;
   logic signed [31:0]        bound_a_ff, bound_b_ff;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [31:0]               rsp_value_ff, rsp_value_in;

   shreg_ctl_type             shreg_ctl;
   bytes_type                 shreg_bytes;
   logic [WORD_BITS-1:0]      sum_word;
   logic [WORD_BITS-1:0]      hi_val, lo_val;
   logic                      div_start;
   logic                      div_done;
   logic [WORD_BITS-1:0]      div_rem;
   logic                      req_accept;
   logic                      out_free;

   bsrr_shreg u_shreg (
      .clock     (clock),
      .reset     (reset),
      .ctl       (shreg_ctl),
      .bytes_out (shreg_bytes)
   );

   bsrr_rem u_rem (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (acc_ff),
      .divisor   (span_ff),
      .done      (div_done),
      .remainder (div_rem)
   );

   // the register accepts a new item only from idle
   assign req_stall  = (state_ff != S_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign out_free   = !rsp_valid_ff || !rsp_stall;

   // word k of the sum is bytes 4k+3..4k packed little-end first
   assign sum_word = shreg_bytes[{wsel_ff, 2'b00} +: 4];

   // order the bounds as signed values
   always_comb begin
      if (bound_a_ff < bound_b_ff) begin
         lo_val = bound_a_ff;
         hi_val = bound_b_ff;
      end else begin
         lo_val = bound_b_ff;
         hi_val = bound_a_ff;
      end
   end

   always_comb begin
      state_in     = state_ff;
      steps_in     = steps_ff;
      wsel_in      = wsel_ff;
      acc_in       = acc_ff;
      lo_in        = lo_ff;
      span_in      = span_ff;
      res_in       = res_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_value_in = rsp_value_ff;
      div_start    = 1'b0;
      shreg_ctl.seed_we   = 1'b0;
      shreg_ctl.seed_idx  = req_seed_index;
      shreg_ctl.seed_byte = req_seed_byte;
      shreg_ctl.adv       = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               if (req_type == REQ_SEED) begin
                  shreg_ctl.seed_we = 1'b1;
               end else begin
                  steps_in = req_steps;
                  state_in = S_ADV;
               end
            end
         end
         S_ADV: begin
            // one register advance per cycle
            if (steps_ff != '0) begin
               shreg_ctl.adv = 1'b1;
               steps_in      = steps_ff - 1'b1;
            end else begin
               wsel_in  = '0;
               acc_in   = '0;
               state_in = S_SUM;
            end
         end
         S_SUM: begin
            acc_in  = acc_ff + sum_word;
            wsel_in = wsel_ff + 1'b1;
            if (wsel_ff == WORD_SEL_BITS'(WORDS - 1)) begin
               state_in = S_PREP;
            end
         end
         S_PREP: begin
            acc_in   = {1'b0, acc_ff[WORD_BITS-1:1]};
            lo_in    = lo_val;
            span_in  = hi_val - lo_val + 32'd1;
            state_in = S_START;
         end
         S_START: begin
            // a span that wraps to zero is the full range
            if (span_ff == '0) begin
               res_in   = acc_ff + lo_ff;
               state_in = S_OUT;
            end else begin
               div_start = 1'b1;
               state_in  = S_DIV;
            end
         end
         S_DIV: begin
            if (div_done) begin
               res_in   = div_rem + lo_ff;
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_value_in = res_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         bound_a_ff   <= '0;
         bound_b_ff   <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we && csr_index == CSR_BOUND_A) begin
            bound_a_ff <= csr_wdata;
         end
         if (csr_we && csr_index == CSR_BOUND_B) begin
            bound_b_ff <= csr_wdata;
         end
      end
      steps_ff     <= steps_in;
      wsel_ff      <= wsel_in;
      acc_ff       <= acc_in;
      lo_ff        <= lo_in;
      span_ff      <= span_in;
      res_ff       <= res_in;
      rsp_value_ff <= rsp_value_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_value = rsp_value_ff;

endmodule
`default_nettype wire

[hdl/bsrr_shreg.sv]
// sixteen byte feedback shift register with byte-wise seed writes
`timescale 1ns / 1ps
`default_nettype none
module bsrr_shreg (
   input  wire                      clock,
   input  wire                      reset,
   input  bsrr_pkg::shreg_ctl_type  ctl,
   output bsrr_pkg::bytes_type      bytes_out
);
   import bsrr_pkg::*;

   bytes_type bytes_ff;
   bytes_type bytes_in;

   always_comb begin
      bytes_in = bytes_ff;
      if (ctl.adv) begin
         // rotate down, old byte 0 folded into every third position
         for (int i = 0; i < NUM_BYTES - 1; i++) begin
            bytes_in[i] = bytes_ff[i+1] ^ ((i % 3 == 0) ? bytes_ff[0] : 8'h00);
         end
         bytes_in[NUM_BYTES-1] = bytes_ff[0];
      end else if (ctl.seed_we) begin
         bytes_in[ctl.seed_idx] = ctl.seed_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bytes_ff <= '0;
      end else begin
         bytes_ff <= bytes_in;
      end
   end

   assign bytes_out = bytes_ff;

endmodule
`default_nettype wire

[hdl/bsrr_rem.sv]
// bit-serial restoring remainder, one dividend bit per cycle
`timescale 1ns / 1ps
`default_nettype none
module bsrr_rem (
   input  wire                              clock,
   input  wire                              reset,
   input  wire                              start,
   input  wire  [bsrr_pkg::WORD_BITS-1:0]   dividend,
   input  wire  [bsrr_pkg::WORD_BITS-1:0]   divisor,
   output logic                             done,
   output logic [bsrr_pkg::WORD_BITS-1:0]   remainder
);
   import bsrr_pkg::*;

   localparam int CNT_BITS = $clog2(WORD_BITS);

   logic                  busy_ff,  busy_in;
   logic                  done_ff,  done_in;
   logic [CNT_BITS-1:0]   cnt_ff,   cnt_in;
   logic [WORD_BITS-1:0]  dvd_ff,   dvd_in;
   logic [WORD_BITS-1:0]  dsr_ff,   dsr_in;
   logic [WORD_BITS-1:0]  rem_ff,   rem_in;
   logic [WORD_BITS:0]    shifted;
   logic [WORD_BITS:0]    trial;

   always_comb begin
      shifted = {rem_ff, dvd_ff[WORD_BITS-1]};
      trial   = shifted - {1'b0, dsr_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      dvd_in  = dvd_ff;
      dsr_in  = dsr_ff;
      rem_in  = rem_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         dvd_in  = dividend;
         dsr_in  = divisor;
         rem_in  = '0;
      end else if (busy_ff) begin
         // keep the trial difference when it does not borrow
         rem_in = trial[WORD_BITS] ? shifted[WORD_BITS-1:0] : trial[WORD_BITS-1:0];
         dvd_in = {dvd_ff[WORD_BITS-2:0], 1'b0};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_BITS'(WORD_BITS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      dvd_ff <= dvd_in;
      dsr_ff <= dsr_in;
      rem_ff <= rem_in;
   end

   assign done      = done_ff;
   assign remainder = rem_ff;

endmodule
`default_nettype wire
